// ===== hdl/wsfr_pkg.sv =====
// Shared types, constants and control structs for the weighted-sum frame receiver.
package wsfr_pkg;

	// Frame geometry
	localparam int MAX_LEN = 64;
	localparam int LEN_W   = 7;
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SUM_W   = 16;
	localparam int TICK_W  = 16;
	localparam int BYTE_W  = 8;

	localparam logic [BYTE_W-1:0] FLUSH_MARK = 8'h5B;

	// Input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_ERROR   = 1'b1;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TIMEOUT = 2'd2;

	localparam logic [LEN_W-1:0]  BUFFER_LIMIT_RST    = 7'd64;
	localparam logic [TICK_W-1:0] SHORT_TIMEOUT_RST   = 16'd50;
	localparam logic [TICK_W-1:0] PAYLOAD_TIMEOUT_RST = 16'd100;

	typedef struct packed {
		logic              operation;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} out_item_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_tick;
		logic out_free;
		logic len_flush;
		logic len_bad;
		logic len_zero;
		logic pay_done;
		logic hi_ok;
		logic lo_ok;
		logic pay_timeout;
		logic short_timeout;
		logic emit_last;
		logic emit_none;
	} dp_status_t;

	// Controller -> datapath
	typedef struct packed {
		logic start_frame;
		logic pay_write;
		logic idle_clr;
		logic idle_inc;
		logic err_load;
		logic emit_clr;
		logic emit_load;
		logic emit_next;
	} dp_cmd_t;

endpackage

// ===== hdl/weighted_sum_frame_receiver_core.sv =====
// Top level of the weighted-sum frame receiver: controller plus datapath.
// Timing: an error result is valid the cycle after its input transfer; a good frame's
//   payload bytes pass from the store through ST_RD and ST_LD into the result register.
// Throughput: one input transfer per cycle outside readout, while the result register
//   is free; readout of a frame holds the input off until its last byte is loaded.
// Reset: clears state, counters and result valid; registers load 64/50/100; store kept.
module weighted_sum_frame_receiver_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [wsfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wsfr_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wsfr_pkg::out_item_t             out_data
);

	wsfr_pkg::dp_status_t sts;
	wsfr_pkg::dp_cmd_t    cmd;

	// Phase tracking and readout sequencing; input is held off while a
	// result sits unaccepted or the store is being walked.
	wsfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Checksum multiply-accumulate, tick counter with saturation, 64-entry
	// payload store and the output register.
	wsfr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== hdl/wsfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/wsfr_datapath.sv =====
// Datapath: config registers, frame counters, checksum, tick counter, store, result register.
module wsfr_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [wsfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wsfr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wsfr_pkg::in_item_t                   in_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output wsfr_pkg::out_item_t                  out_data,
	input  wsfr_pkg::dp_cmd_t                    cmd,
	output wsfr_pkg::dp_status_t                 sts
);

	logic [wsfr_pkg::LEN_W-1:0]  buf_limit_q;
	logic [wsfr_pkg::TICK_W-1:0] short_to_q;
	logic [wsfr_pkg::TICK_W-1:0] pay_to_q;

	logic [wsfr_pkg::LEN_W-1:0]  frame_len_q;
	logic [wsfr_pkg::LEN_W-1:0]  byte_cnt_q;
	logic [wsfr_pkg::SUM_W-1:0]  sum_q;
	logic [wsfr_pkg::TICK_W-1:0] idle_q;
	logic [wsfr_pkg::IDX_W-1:0]  emit_idx_q;

	logic                        out_valid_q;
	wsfr_pkg::out_item_t         out_q;

	logic [wsfr_pkg::LEN_W-1:0]  weight;
	logic [14:0]                 prod;
	logic [wsfr_pkg::SUM_W-1:0]  sum_next;
	logic [wsfr_pkg::TICK_W-1:0] idle_next;
	logic [wsfr_pkg::BYTE_W-1:0] ram_rdata;
	logic [wsfr_pkg::BYTE_W-1:0] rx;

	assign rx = in_data.rx_byte;

	// position weight: byte_cnt counts from 0, length byte holds position 1
	assign weight    = byte_cnt_q + wsfr_pkg::LEN_W'(2);
	assign prod      = 15'(rx) * 15'(weight);
	assign sum_next  = sum_q + wsfr_pkg::SUM_W'(prod);
	assign idle_next = (idle_q == '1) ? idle_q : idle_q + wsfr_pkg::TICK_W'(1);

	always_comb begin
		sts.is_tick       = (in_data.operation == wsfr_pkg::OP_TICK);
		sts.out_free      = !out_valid_q || out_ready;
		sts.len_flush     = (rx == wsfr_pkg::FLUSH_MARK);
		sts.len_bad       = (rx > wsfr_pkg::BYTE_W'(wsfr_pkg::MAX_LEN))
			|| (rx > wsfr_pkg::BYTE_W'(buf_limit_q));
		sts.len_zero      = (rx == '0);
		sts.pay_done      = ((byte_cnt_q + wsfr_pkg::LEN_W'(1)) >= frame_len_q);
		sts.hi_ok         = (sum_q[15:8] == rx);
		sts.lo_ok         = (sum_q[7:0] == rx);
		sts.pay_timeout   = (idle_next >= pay_to_q);
		sts.short_timeout = (idle_next >= short_to_q);
		sts.emit_last     = ((wsfr_pkg::LEN_W'(emit_idx_q) + wsfr_pkg::LEN_W'(1)) == frame_len_q);
		sts.emit_none     = (frame_len_q == '0);
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_limit_q <= wsfr_pkg::BUFFER_LIMIT_RST;
			short_to_q  <= wsfr_pkg::SHORT_TIMEOUT_RST;
			pay_to_q    <= wsfr_pkg::PAYLOAD_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wsfr_pkg::REG_BUFFER_LIMIT:    buf_limit_q <= cfg_wdata[wsfr_pkg::LEN_W-1:0];
				wsfr_pkg::REG_SHORT_TIMEOUT:   short_to_q  <= cfg_wdata[wsfr_pkg::TICK_W-1:0];
				wsfr_pkg::REG_PAYLOAD_TIMEOUT: pay_to_q    <= cfg_wdata[wsfr_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= '0;
			byte_cnt_q  <= '0;
			sum_q       <= '0;
			idle_q      <= '0;
			emit_idx_q  <= '0;
		end else begin
			if (cmd.start_frame) begin
				frame_len_q <= rx[wsfr_pkg::LEN_W-1:0];
				byte_cnt_q  <= '0;
				sum_q       <= wsfr_pkg::SUM_W'(rx);
			end else if (cmd.pay_write) begin
				byte_cnt_q  <= byte_cnt_q + wsfr_pkg::LEN_W'(1);
				sum_q       <= sum_next;
			end
			if (cmd.idle_clr) begin
				idle_q <= '0;
			end else if (cmd.idle_inc) begin
				idle_q <= idle_next;
			end
			if (cmd.emit_clr) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_next) begin
				emit_idx_q <= emit_idx_q + wsfr_pkg::IDX_W'(1);
			end
		end
	end

	wsfr_ram #(
		.WIDTH (wsfr_pkg::BYTE_W),
		.DEPTH (wsfr_pkg::MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (cmd.pay_write),
		.waddr (byte_cnt_q[wsfr_pkg::IDX_W-1:0]),
		.wdata (rx),
		.raddr (emit_idx_q),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.err_load || cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_load) begin
			out_q.kind <= wsfr_pkg::KIND_ERROR;
			out_q.data <= '0;
			out_q.last <= 1'b1;
		end else if (cmd.emit_load) begin
			out_q.kind <= wsfr_pkg::KIND_PAYLOAD;
			out_q.data <= ram_rdata;
			out_q.last <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/wsfr_ctrl.sv =====
// Controller: frame phase state machine and payload readout sequencer.
module wsfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wsfr_pkg::dp_status_t sts,
	output wsfr_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_LEN,
		ST_PAY,
		ST_SHI,
		ST_SLO,
		ST_FLUSH,
		ST_RD,
		ST_LD
	} ctl_state_t;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       accept;
	logic       timeout;

	assign in_ready = sts.out_free && (state_q inside {ST_LEN, ST_PAY, ST_SHI, ST_SLO, ST_FLUSH});
	assign accept   = in_valid && in_ready;
	assign timeout  = (state_q == ST_PAY) ? sts.pay_timeout : sts.short_timeout;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_RD: begin
				state_d = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.emit_next = 1'b1;
						state_d       = ST_RD;
					end
				end
			end
			default: begin
				if (accept && sts.is_tick) begin
					if (state_q == ST_LEN) begin
						cmd.idle_clr = 1'b1;
					end else begin
						cmd.idle_inc = 1'b1;
						if (timeout) begin
							cmd.idle_clr = 1'b1;
							state_d      = ST_LEN;
							if (state_q != ST_FLUSH) begin
								cmd.err_load = 1'b1;
							end
						end
					end
				end else if (accept) begin
					cmd.idle_clr = 1'b1;
					case (state_q)
						ST_LEN: begin
							if (sts.len_flush) begin
								state_d = ST_FLUSH;
							end else if (sts.len_bad) begin
								cmd.err_load = 1'b1;
							end else begin
								cmd.start_frame = 1'b1;
								state_d = sts.len_zero ? ST_SHI : ST_PAY;
							end
						end
						ST_PAY: begin
							cmd.pay_write = 1'b1;
							if (sts.pay_done) begin
								state_d = ST_SHI;
							end
						end
						ST_SHI: begin
							if (sts.hi_ok) begin
								state_d = ST_SLO;
							end else begin
								cmd.err_load = 1'b1;
								state_d      = ST_LEN;
							end
						end
						ST_SLO: begin
							if (!sts.lo_ok) begin
								cmd.err_load = 1'b1;
								state_d      = ST_LEN;
							end else if (sts.emit_none) begin
								state_d = ST_FLUSH;
							end else begin
								cmd.emit_clr = 1'b1;
								state_d      = ST_RD;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LEN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/wsfr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
module wsfr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input wsfr_pkg::in_item_t              in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input wsfr_pkg::out_item_t             out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// waiting input transfer holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed while waiting");

	// error results carry zero data and are marked last
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == wsfr_pkg::KIND_ERROR)
		|-> (out_data.data == '0) && out_data.last)
		else $error("malformed error result");

	// no input transfer while a result is stuck in the output register
	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while output stalled");

	// a stalled non-last payload result is followed by input being held off
	a_readout_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && (out_data.kind == wsfr_pkg::KIND_PAYLOAD)
		&& !out_data.last |=> !in_ready)
		else $error("input ready in the middle of a frame readout");

endmodule

bind weighted_sum_frame_receiver_core wsfr_checker u_wsfr_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the weighted-sum frame receiver core.

typedef enum logic [2:0] {
	RX_WAIT_LEN,
	RX_PAYLOAD,
	RX_SUM_HI,
	RX_SUM_LO,
	RX_FLUSH
} rx_phase_t;

typedef enum int {
	FAULT_NONE,
	FAULT_SUM_HI,
	FAULT_SUM_LO,
	FAULT_PAY_TIMEOUT,
	FAULT_SUM_TIMEOUT
} frame_fault_t;

// Tracks the receiver state, predicts the result bytes of each transfer
// and checks what comes out in order.
class rx_frame_tracker;
	logic [wsfr_pkg::LEN_W-1:0]  buf_limit;
	logic [wsfr_pkg::TICK_W-1:0] short_to;
	logic [wsfr_pkg::TICK_W-1:0] pay_to;

	rx_phase_t                   cur_phase;
	logic [wsfr_pkg::LEN_W-1:0]  frame_len;
	logic [wsfr_pkg::LEN_W-1:0]  byte_cnt;
	logic [wsfr_pkg::SUM_W-1:0]  sum_acc;
	logic [wsfr_pkg::TICK_W-1:0] idle_cnt;
	logic [7:0]                  payload_mem [wsfr_pkg::MAX_LEN];

	wsfr_pkg::out_item_t         results_due [$];
	int                          errors;

	function new();
		buf_limit = wsfr_pkg::BUFFER_LIMIT_RST;
		short_to  = wsfr_pkg::SHORT_TIMEOUT_RST;
		pay_to    = wsfr_pkg::PAYLOAD_TIMEOUT_RST;
		cur_phase = RX_WAIT_LEN;
		frame_len = '0;
		byte_cnt  = '0;
		sum_acc   = '0;
		idle_cnt  = '0;
		errors    = 0;
	endfunction

	function void set_reg(logic [wsfr_pkg::CFG_IDX_W-1:0] idx,
		logic [wsfr_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			wsfr_pkg::REG_BUFFER_LIMIT:    buf_limit = val[wsfr_pkg::LEN_W-1:0];
			wsfr_pkg::REG_SHORT_TIMEOUT:   short_to  = val;
			wsfr_pkg::REG_PAYLOAD_TIMEOUT: pay_to    = val;
			default: ;
		endcase
	endfunction

	function void raise_error();
		wsfr_pkg::out_item_t r;
		r.kind = wsfr_pkg::KIND_ERROR;
		r.data = '0;
		r.last = 1'b1;
		cur_phase = RX_WAIT_LEN;
		idle_cnt  = '0;
		results_due.push_back(r);
	endfunction

	// Returns 0 when the transfer is simply ignored by the receiver.
	function bit take_input(wsfr_pkg::in_item_t it);
		logic [wsfr_pkg::TICK_W-1:0] lim;
		wsfr_pkg::out_item_t r;
		int i;
		if (it.operation == wsfr_pkg::OP_TICK) begin
			if (cur_phase == RX_WAIT_LEN) begin
				idle_cnt = '0;
				return 1'b0;
			end
			if (idle_cnt != 16'hFFFF)
				idle_cnt = idle_cnt + 1'b1;
			lim = (cur_phase == RX_PAYLOAD) ? pay_to : short_to;
			if (idle_cnt < lim)
				return 1'b1;
			if (cur_phase == RX_FLUSH) begin
				cur_phase = RX_WAIT_LEN;
				idle_cnt  = '0;
			end else begin
				raise_error();
			end
			return 1'b1;
		end
		idle_cnt = '0;
		case (cur_phase)
			RX_WAIT_LEN: begin
				if (it.rx_byte == wsfr_pkg::FLUSH_MARK) begin
					cur_phase = RX_FLUSH;
				end else if (it.rx_byte > wsfr_pkg::MAX_LEN || it.rx_byte > buf_limit) begin
					raise_error();
				end else begin
					frame_len = it.rx_byte[wsfr_pkg::LEN_W-1:0];
					byte_cnt  = '0;
					sum_acc   = {8'd0, it.rx_byte};
					cur_phase = (it.rx_byte == 8'd0) ? RX_SUM_HI : RX_PAYLOAD;
				end
			end
			RX_PAYLOAD: begin
				payload_mem[byte_cnt[wsfr_pkg::IDX_W-1:0]] = it.rx_byte;
				sum_acc  = 16'(int'(sum_acc) + int'(it.rx_byte) * (int'(byte_cnt) + 2));
				byte_cnt = byte_cnt + 1'b1;
				if (byte_cnt >= frame_len)
					cur_phase = RX_SUM_HI;
			end
			RX_SUM_HI: begin
				if (sum_acc[15:8] != it.rx_byte)
					raise_error();
				else
					cur_phase = RX_SUM_LO;
			end
			RX_SUM_LO: begin
				if (sum_acc[7:0] != it.rx_byte) begin
					raise_error();
				end else begin
					cur_phase = RX_FLUSH;
					for (i = 0; i < int'(frame_len); i++) begin
						r.kind = wsfr_pkg::KIND_PAYLOAD;
						r.data = payload_mem[i];
						r.last = (i + 1 == int'(frame_len));
						results_due.push_back(r);
					end
				end
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function void match_result(wsfr_pkg::out_item_t got);
		wsfr_pkg::out_item_t want;
		if (results_due.size() == 0) begin
			$display("%0t: unexpected result kind=%0d data=%02h last=%0d",
				$time, got.kind, got.data, got.last);
			errors++;
			return;
		end
		want = results_due.pop_front();
		if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last) begin
			$display("%0t: result mismatch exp kind=%0d data=%02h last=%0d,",
				$time, want.kind, want.data, want.last);
			$display("%0t:   got kind=%0d data=%02h last=%0d",
				$time, got.kind, got.data, got.last);
			errors++;
		end
	endfunction
endclass

module tb;
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [wsfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [wsfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	wsfr_pkg::in_item_t              in_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	wsfr_pkg::out_item_t             out_data;

	rx_frame_tracker tracker = new();

	int fed;           // transfers that actually move the receiver state
	int sent;
	int in_idle_pct = 20;
	int out_idle_pct = 20;
	int out_cycles;
	int stall_left;
	bit quiet;         // no idling on either side in the closing stretch

	weighted_sum_frame_receiver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: ready drops in short random bursts; the burst rate is
	// re-rolled now and then so some stretches see no back-pressure at all.
	always @(negedge clk) begin
		out_cycles++;
		if (out_cycles % 40 == 0) begin
			case ($urandom_range(0, 2))
				0: out_idle_pct = 0;
				1: out_idle_pct = 20;
				default: out_idle_pct = 50;
			endcase
		end
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(1, 3) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_result(out_data);
	end

	// One input transfer; entered and left at a falling edge. Valid stays
	// high after the transfer so back-to-back items need no re-raise.
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data.operation = op;
		// byte field is don't-care on a tick, so let it wander
		in_data.rx_byte = (op == wsfr_pkg::OP_TICK) ? 8'($urandom) : b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (tracker.take_input(in_data))
			fed++;
		@(negedge clk);
		sent++;
		if (sent % 32 == 0) begin
			case ($urandom_range(0, 2))
				0: in_idle_pct = 0;
				1: in_idle_pct = 20;
				default: in_idle_pct = 50;
			endcase
		end
	endtask

	task automatic byte_item(input logic [7:0] b);
		send_item(wsfr_pkg::OP_BYTE, b);
	endtask

	task automatic tick_items(input int n);
		repeat (n) send_item(wsfr_pkg::OP_TICK, 8'd0);
	endtask

	// A few idle ticks, always short of the given timeout.
	task automatic gap_ticks(input logic [wsfr_pkg::TICK_W-1:0] lim);
		if (lim > 1 && $urandom_range(0, 3) == 0)
			tick_items($urandom_range(1, (int'(lim) - 1 < 3) ? int'(lim) - 1 : 3));
	endtask

	// Line noise during a flush, then enough silence to end it when that is cheap.
	task automatic flush_tail();
		repeat ($urandom_range(0, 3)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
		if (tracker.short_to <= 16)
			tick_items(int'(tracker.short_to));
	endtask

	task automatic write_reg(input logic [wsfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [wsfr_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.set_reg(idx, val);
	endtask

	// Drop valid, wait out every predicted result, then let the core go quiet.
	task automatic settle();
		in_valid = 1'b0;
		while (tracker.results_due.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Steer the receiver back to waiting for a length byte; a broken checksum
	// is the quick way out of a frame. A flush with a huge timeout is left alone.
	task automatic to_waiting();
		int guard;
		guard = 0;
		while (tracker.cur_phase != RX_WAIT_LEN && guard < 200) begin
			guard++;
			case (tracker.cur_phase)
				RX_PAYLOAD: byte_item(8'($urandom));
				RX_SUM_HI:  byte_item(~tracker.sum_acc[15:8]);
				RX_SUM_LO:  byte_item(~tracker.sum_acc[7:0]);
				default: begin
					if (tracker.short_to > 16)
						return;
					send_item(wsfr_pkg::OP_TICK, 8'd0);
				end
			endcase
		end
	endtask

	// Length byte, random payload with short gaps, checksum, and the chosen fault.
	task automatic send_frame(input int len, input frame_fault_t fault);
		logic [7:0]                 body [wsfr_pkg::MAX_LEN];
		logic [wsfr_pkg::SUM_W-1:0] csum;
		logic [7:0]                 hi_b;
		logic [7:0]                 lo_b;
		frame_fault_t               f;
		int                         stop;
		int                         i;
		f = fault;
		if (f == FAULT_PAY_TIMEOUT && (len == 0 || tracker.pay_to > 16))
			f = FAULT_SUM_HI;
		if (f == FAULT_SUM_TIMEOUT && tracker.short_to > 16)
			f = FAULT_SUM_LO;
		csum = 16'(len);
		for (i = 0; i < len; i++) begin
			body[i] = 8'($urandom);
			csum = 16'(int'(csum) + int'(body[i]) * (i + 2));
		end
		byte_item(8'(len));
		stop = (f == FAULT_PAY_TIMEOUT) ? $urandom_range(0, len - 1) : len;
		for (i = 0; i < stop; i++) begin
			gap_ticks(tracker.pay_to);
			byte_item(body[i]);
		end
		if (f == FAULT_PAY_TIMEOUT) begin
			tick_items(int'(tracker.pay_to));
			return;
		end
		gap_ticks(tracker.short_to);
		if (f == FAULT_SUM_TIMEOUT && $urandom_range(0, 1) == 0) begin
			tick_items(int'(tracker.short_to));
			return;
		end
		hi_b = csum[15:8];
		if (f == FAULT_SUM_HI)
			hi_b = hi_b ^ (8'd1 << $urandom_range(0, 7));
		byte_item(hi_b);
		if (f == FAULT_SUM_HI)
			return;
		gap_ticks(tracker.short_to);
		if (f == FAULT_SUM_TIMEOUT) begin
			tick_items(int'(tracker.short_to));
			return;
		end
		lo_b = csum[7:0];
		if (f == FAULT_SUM_LO)
			lo_b = lo_b ^ (8'd1 << $urandom_range(0, 7));
		byte_item(lo_b);
		if (f == FAULT_NONE)
			flush_tail();
	endtask

	// Mostly well-formed frames with random content; the rest is broken
	// frames, bad lengths, raw noise and flush marks.
	task automatic run_random(input int target);
		int start;
		int seqs;
		int pick;
		int lim;
		int len;
		start = fed;
		seqs = 0;
		while (fed - start < target && seqs < 120) begin
			seqs++;
			pick = $urandom_range(0, 99);
			lim = int'(tracker.buf_limit);
			if (pick < 55) begin
				to_waiting();
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lim)
					: $urandom_range(0, (lim < 6) ? lim : 6);
				send_frame(len, FAULT_NONE);
			end else if (pick < 75) begin
				to_waiting();
				len = $urandom_range(0, (lim < 6) ? lim : 6);
				send_frame(len, frame_fault_t'($urandom_range(1, 4)));
			end else if (pick < 85) begin
				to_waiting();
				byte_item(8'($urandom_range(lim + 1, 255)));
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 6))
					send_item(1'($urandom_range(0, 1)), 8'($urandom));
			end else begin
				to_waiting();
				byte_item(wsfr_pkg::FLUSH_MARK);
				flush_tail();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: tight timeouts so every exit path is cheap to reach
		write_reg(wsfr_pkg::REG_BUFFER_LIMIT, 16'd64);
		write_reg(wsfr_pkg::REG_SHORT_TIMEOUT, 16'd2);
		write_reg(wsfr_pkg::REG_PAYLOAD_TIMEOUT, 16'd3);
		tick_items(1);                       // tick while waiting: nothing
		byte_item(8'd65);                    // length just past the maximum
		byte_item(8'hFF);
		send_frame(0, FAULT_NONE);           // empty frame, good checksum: silent
		send_frame(1, FAULT_NONE);
		byte_item(wsfr_pkg::FLUSH_MARK);     // silent flush, then silence ends it
		tick_items(2);
		send_frame(0, FAULT_SUM_LO);         // empty frame, bad checksum
		send_frame(2, FAULT_PAY_TIMEOUT);
		send_frame(0, FAULT_SUM_TIMEOUT);
		settle();

		// moderate timeouts
		write_reg(wsfr_pkg::REG_SHORT_TIMEOUT, 16'd3);
		write_reg(wsfr_pkg::REG_PAYLOAD_TIMEOUT, 16'd4);
		to_waiting();
		run_random(140);
		settle();

		// smallest limits: only empty frames pass, any tick in a frame fails
		write_reg(wsfr_pkg::REG_BUFFER_LIMIT, 16'd0);
		write_reg(wsfr_pkg::REG_SHORT_TIMEOUT, 16'd1);
		write_reg(wsfr_pkg::REG_PAYLOAD_TIMEOUT, 16'd1);
		to_waiting();
		run_random(40);
		settle();

		// widest payload timeout, full-size frame up front
		write_reg(wsfr_pkg::REG_BUFFER_LIMIT, 16'd64);
		write_reg(wsfr_pkg::REG_SHORT_TIMEOUT, 16'd4);
		write_reg(wsfr_pkg::REG_PAYLOAD_TIMEOUT, 16'hFFFF);
		to_waiting();
		send_frame(wsfr_pkg::MAX_LEN, FAULT_NONE);
		run_random(90);
		settle();

		// widest short timeout: a flush never ends here
		write_reg(wsfr_pkg::REG_BUFFER_LIMIT, 16'd10);
		write_reg(wsfr_pkg::REG_SHORT_TIMEOUT, 16'hFFFF);
		write_reg(wsfr_pkg::REG_PAYLOAD_TIMEOUT, 16'd2);
		to_waiting();
		run_random(30);
		settle();

		// closing stretch: random setting, no idling anywhere
		quiet = 1'b1;
		write_reg(wsfr_pkg::REG_BUFFER_LIMIT, 16'($urandom_range(1, 63)));
		write_reg(wsfr_pkg::REG_SHORT_TIMEOUT, 16'($urandom_range(1, 6)));
		write_reg(wsfr_pkg::REG_PAYLOAD_TIMEOUT, 16'($urandom_range(2, 8)));
		to_waiting();
		run_random(100);
		settle();

		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#10000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
